FILE: rtl/ssc_pkg.sv
// shared types for the sphere-sphere collision pipeline
// used by every module of the block; no dependencies
`default_nettype none
package ssc_pkg;

    localparam int unsigned LANES = 3;

    localparam logic [2:0] REG_OWN_RADIUS   = 3'd0;
    localparam logic [2:0] REG_OWN_OFFSET_X = 3'd1;
    localparam logic [2:0] REG_OWN_OFFSET_Y = 3'd2;
    localparam logic [2:0] REG_OWN_OFFSET_Z = 3'd3;
    localparam logic [2:0] REG_OWN_ACTIVE   = 3'd4;

    typedef struct packed {
        logic signed [31:0] own_pos_x;
        logic signed [31:0] own_pos_y;
        logic signed [31:0] own_pos_z;
        logic signed [31:0] other_pos_x;
        logic signed [31:0] other_pos_y;
        logic signed [31:0] other_pos_z;
        logic signed [31:0] other_offset_x;
        logic signed [31:0] other_offset_y;
        logic signed [31:0] other_offset_z;
        logic [30:0]        other_radius;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic [31:0]        penetration;
    } out_item_t;

    typedef struct packed {
        logic              hit;
        logic [2:0]        sign;
        logic [2:0][31:0]  mag;
        logic [31:0]       radius_sum;
    } geo_t;

endpackage
`default_nettype wire

FILE: rtl/ssc_front.sv
// center difference, magnitudes, squares and hit test: four register stages
// depends on ssc_pkg
`default_nettype none
module ssc_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             in_valid,
    input  wire ssc_pkg::in_item_t in_item,
    input  wire logic [30:0]      own_radius,
    input  wire logic [2:0][31:0] own_offset,
    input  wire logic             own_active,
    output logic                  geo_valid,
    output ssc_pkg::geo_t         geo,
    output logic [63:0]           dist_sq
);

    logic [3:0] v_reg;

    logic signed [2:0][33:0] d_reg;
    logic [31:0]             r1_reg;
    logic                    act1_reg;

    logic [2:0][31:0] m_reg;
    logic [2:0]       s2_reg;
    logic             fit2_reg;
    logic [31:0]      r2_reg;
    logic             act2_reg;

    logic [2:0][63:0] sq_reg;
    logic [63:0]      rr_reg;
    logic [2:0]       s3_reg;
    logic [2:0][31:0] m3_reg;
    logic             fit3_reg;
    logic [31:0]      r3_reg;
    logic             act3_reg;

    ssc_pkg::geo_t    geo_reg;
    logic [63:0]      s_reg;

    logic signed [2:0][33:0] d_next;
    logic [2:0][33:0]        mag_next;
    logic [65:0]             sum_next;
    logic [2:0][31:0]        own_pos;
    logic [2:0][31:0]        oth_pos;
    logic [2:0][31:0]        oth_off;

    assign own_pos = {in_item.own_pos_z, in_item.own_pos_y, in_item.own_pos_x};
    assign oth_pos = {in_item.other_pos_z, in_item.other_pos_y, in_item.other_pos_x};
    assign oth_off = {in_item.other_offset_z, in_item.other_offset_y,
                      in_item.other_offset_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_next[i] = (34'(signed'(oth_pos[i])) + 34'(signed'(oth_off[i])))
                      - (34'(signed'(own_pos[i])) + 34'(signed'(own_offset[i])));
            mag_next[i] = d_reg[i][33] ? 34'(-d_reg[i]) : 34'(d_reg[i]);
        end
        sum_next = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg    <= d_next;
            r1_reg   <= {1'b0, own_radius} + {1'b0, in_item.other_radius};
            act1_reg <= own_active;

            for (int i = 0; i < 3; i++)
            begin
                m_reg[i]  <= mag_next[i][31:0];
                s2_reg[i] <= d_reg[i][33];
            end
            fit2_reg <= (mag_next[0][33:32] == 2'b00) && (mag_next[1][33:32] == 2'b00)
                     && (mag_next[2][33:32] == 2'b00);
            r2_reg   <= r1_reg;
            act2_reg <= act1_reg;

            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= m_reg[i] * m_reg[i];
            end
            rr_reg   <= r2_reg * r2_reg;
            s3_reg   <= s2_reg;
            m3_reg   <= m_reg;
            fit3_reg <= fit2_reg;
            r3_reg   <= r2_reg;
            act3_reg <= act2_reg;

            geo_reg.hit        <= fit3_reg && act3_reg && (sum_next[65:64] == 2'b00)
                               && (sum_next[63:0] <= rr_reg);
            geo_reg.sign       <= s3_reg;
            geo_reg.mag        <= m3_reg;
            geo_reg.radius_sum <= r3_reg;
            s_reg              <= sum_next[63:0];
        end
    end

    assign geo_valid = v_reg[3];
    assign geo       = geo_reg;
    assign dist_sq   = s_reg;

endmodule
`default_nettype wire

FILE: rtl/ssc_sqrt.sv
// pipelined integer square root, one result bit per stage, 32 stages
// depends on ssc_pkg
`default_nettype none
module ssc_sqrt (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire ssc_pkg::geo_t in_geo,
    input  wire logic [63:0]   in_sq,
    output logic               out_valid,
    output ssc_pkg::geo_t      out_geo,
    output logic [31:0]        root
);

    localparam int STEPS = 32;

    logic                v_reg   [0:STEPS-1];
    ssc_pkg::geo_t       geo_reg [0:STEPS-1];
    logic [63:0]         x_reg   [0:STEPS-1];
    logic [63:0]         res_reg [0:STEPS-1];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            logic          v_in;
            ssc_pkg::geo_t g_in;
            logic [63:0]   x_in;
            logic [63:0]   r_in;
            logic [63:0]   trial;
            logic          take;

            if (k == 0)
            begin : g_first
                assign v_in = in_valid;
                assign g_in = in_geo;
                assign x_in = in_sq;
                assign r_in = '0;
            end
            else
            begin : g_rest
                assign v_in = v_reg[k-1];
                assign g_in = geo_reg[k-1];
                assign x_in = x_reg[k-1];
                assign r_in = res_reg[k-1];
            end

            assign trial = r_in + BIT;
            assign take  = (x_in >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    geo_reg[k] <= g_in;
                    x_reg[k]   <= take ? x_in - trial : x_in;
                    res_reg[k] <= take ? (r_in >> 1) + BIT : r_in >> 1;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[STEPS-1];
    assign out_geo   = geo_reg[STEPS-1];
    assign root      = res_reg[STEPS-1][31:0];

endmodule
`default_nettype wire

FILE: rtl/ssc_norm.sv
// three-lane pipelined restoring divider for the unit normal, plus result stage
// depends on ssc_pkg
`default_nettype none
module ssc_norm (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          in_valid,
    input  wire ssc_pkg::geo_t in_geo,
    input  wire logic [31:0]   in_dist,
    output logic               out_valid,
    output ssc_pkg::out_item_t out_item
);

    localparam int STEPS = 31;

    logic                v_reg    [0:STEPS-1];
    ssc_pkg::geo_t       geo_reg  [0:STEPS-1];
    logic [31:0]         dist_reg [0:STEPS-1];
    logic [31:0]         rem_reg  [0:STEPS-1][0:ssc_pkg::LANES-1];
    logic [30:0]         q_reg    [0:STEPS-1][0:ssc_pkg::LANES-1];

    logic                out_v_reg;
    ssc_pkg::out_item_t  out_reg;
    ssc_pkg::out_item_t  out_next;

    genvar j, l;
    generate
        for (j = 0; j < STEPS; j++)
        begin : g_step
            logic          v_in;
            ssc_pkg::geo_t g_in;
            logic [31:0]   dv_in;

            if (j == 0)
            begin : g_first
                assign v_in  = in_valid;
                assign g_in  = in_geo;
                assign dv_in = in_dist;
            end
            else
            begin : g_rest
                assign v_in  = v_reg[j-1];
                assign g_in  = geo_reg[j-1];
                assign dv_in = dist_reg[j-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[j] <= 1'b0;
                end
                else if (adv)
                begin
                    v_reg[j] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    geo_reg[j]  <= g_in;
                    dist_reg[j] <= dv_in;
                end
            end

            for (l = 0; l < ssc_pkg::LANES; l++)
            begin : g_lane
                logic [32:0] cand;
                logic [30:0] q_in;
                logic        ge;

                if (j == 0)
                begin : g_first
                    assign cand = {1'b0, in_geo.mag[l]};
                    assign q_in = '0;
                end
                else
                begin : g_rest
                    assign cand = {rem_reg[j-1][l], 1'b0};
                    assign q_in = q_reg[j-1][l];
                end

                assign ge = (cand >= {1'b0, dv_in});

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        rem_reg[j][l] <= ge ? 32'(cand - {1'b0, dv_in}) : cand[31:0];
                        q_reg[j][l]   <= {q_in[29:0], ge};
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        logic [2:0][31:0] nrm;
        ssc_pkg::geo_t    g;
        logic [31:0]      dv;
        g  = geo_reg[STEPS-1];
        dv = dist_reg[STEPS-1];
        for (int i = 0; i < 3; i++)
        begin
            if (g.hit && (dv != '0))
            begin
                nrm[i] = g.sign[i] ? 32'(-{1'b0, q_reg[STEPS-1][i]})
                                   : {1'b0, q_reg[STEPS-1][i]};
            end
            else
            begin
                nrm[i] = '0;
            end
        end
        out_next.hit         = g.hit;
        out_next.normal_x    = nrm[0];
        out_next.normal_y    = nrm[1];
        out_next.normal_z    = nrm[2];
        out_next.penetration = g.hit ? g.radius_sum - dv : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= v_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_item  = out_reg;

endmodule
`default_nettype wire

FILE: rtl/sphere_sphere_collision_unit.sv
// top level of the sphere-sphere collision test: configuration registers and pipeline
// depends on ssc_pkg, ssc_front, ssc_sqrt, ssc_norm
//
// usage:
//   input items (in_item) enter on in_valid with in_stall low; each item is one
//   test of the own sphere against another sphere. one result item leaves per
//   input item on out_valid with out_stall low, in input order.
//   configuration is written through cfg_we / cfg_index / cfg_data while idle:
//   index 0 own radius, 1..3 own offset x/y/z, 4 own active flag.
//   the pipeline has 4 front stages (center difference, magnitude,
//   squares, hit compare), 32 square root stages (one root bit each), 31
//   divider stages (one normal bit each) and the result register.
//   throughput is one item per cycle while a stalled result does not hold the pipeline.
//   reset clears all valid bits and configuration registers.
//   when the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises; no item is lost or repeated.
`default_nettype none
module sphere_sphere_collision_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ssc_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output ssc_pkg::out_item_t      out_item,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    logic [30:0]      radius_reg;
    logic [2:0][31:0] offset_reg;
    logic             active_reg;

    logic             adv;
    logic             f_valid;
    ssc_pkg::geo_t    f_geo;
    logic [63:0]      f_sq;
    logic             r_valid;
    ssc_pkg::geo_t    r_geo;
    logic [31:0]      r_dist;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            offset_reg <= '0;
            active_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssc_pkg::REG_OWN_RADIUS:   radius_reg    <= cfg_data[30:0];
                ssc_pkg::REG_OWN_OFFSET_X: offset_reg[0] <= cfg_data;
                ssc_pkg::REG_OWN_OFFSET_Y: offset_reg[1] <= cfg_data;
                ssc_pkg::REG_OWN_OFFSET_Z: offset_reg[2] <= cfg_data;
                ssc_pkg::REG_OWN_ACTIVE:   active_reg    <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    ssc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .own_radius (radius_reg),
        .own_offset (offset_reg),
        .own_active (active_reg),
        .geo_valid  (f_valid),
        .geo        (f_geo),
        .dist_sq    (f_sq)
    );

    ssc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .in_geo    (f_geo),
        .in_sq     (f_sq),
        .out_valid (r_valid),
        .out_geo   (r_geo),
        .root      (r_dist)
    );

    ssc_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (r_valid),
        .in_geo    (r_geo),
        .in_dist   (r_dist),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire
